// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the front, queue and back rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clk edge outside of reset
`define LDBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clk edge, reset included
`define LDBE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ldbe_pkg.sv =====
`default_nettype none

package ldbe_pkg;

  // field widths
  localparam int LEN_W  = 24;
  localparam int LINE_W = 31;
  localparam int POS_W  = 32;
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int PEND_W = 7;
  localparam int PCNT_W = 3;

  // bit accumulator: up to 7 pending bits plus the 35-bit escape code
  localparam int ACC_W   = 48;
  localparam int NBITS_W = 6;

  // header layout
  localparam int HEADER_BASE      = 4;
  localparam int CHECKPOINT_BYTES = 8;

  // prefix codes
  localparam logic [1:0] PFX_SHORT = 2'h2;
  localparam logic [2:0] PFX_MID   = 3'h6;
  localparam logic [2:0] PFX_LONG  = 3'h7;

  // code lengths in bits
  localparam logic [NBITS_W-1:0] CODE_LEN_SAME  = 6'd1;
  localparam logic [NBITS_W-1:0] CODE_LEN_SHORT = 6'd4;
  localparam logic [NBITS_W-1:0] CODE_LEN_MID   = 6'd11;
  localparam logic [NBITS_W-1:0] CODE_LEN_LONG  = 6'd35;

  // delta ranges
  localparam int SHORT_MAX = 4;
  localparam int MID_MIN   = -128;
  localparam int MID_MAX   = 127;
  localparam int MID_BIAS  = 128;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE,
    KIND_CHECKPOINT,
    KIND_END
  } kind_t;

  // result slots of one job, in delivery order
  localparam int MAX_STREAM_BYTES = 5;
  localparam int SLOT_PRE    = 0;
  localparam int SLOT_CKPT   = 1;
  localparam int SLOT_B0     = 2;
  localparam int SLOT_EFLUSH = SLOT_B0 + MAX_STREAM_BYTES;
  localparam int SLOT_END    = SLOT_EFLUSH + 1;
  localparam int NUM_SLOTS   = SLOT_END + 1;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]             mask;
    logic [NUM_SLOTS-1:0][BYTE_W-1:0] bytes;
    logic [LINE_W-1:0]                line;
    logic [POS_W-1:0]                 ckpt_off;
    logic [POS_W-1:0]                 end_size;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ldbe_if.sv =====
`default_nettype none

interface ldbe_line_if import ldbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] source_line;

  modport source (output valid, output source_line, input ready);
  modport sink (input valid, input source_line, output ready);
endinterface

interface ldbe_rec_if import ldbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] data_byte;
  logic [LINE_W-1:0] checkpoint_line;
  logic [POS_W-1:0]  byte_offset;
  logic              last_of_run;

  modport source (output valid, output kind, output data_byte, output checkpoint_line,
                  output byte_offset, output last_of_run, input ready);
  modport sink (input valid, input kind, input data_byte, input checkpoint_line,
                input byte_offset, input last_of_run, output ready);
endinterface

interface ldbe_cfg_if import ldbe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] program_length;

  modport source (output valid, output program_length, input ready);
  modport sink (input valid, input program_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/line_delta_bitpack_encoder.sv =====
// line_delta_bitpack_encoder turns one source line number per instruction into a packed
// delta stream with a checkpoint record at the start of every CHECKPOINT_SPACING
// instructions and an end record carrying the total size once program_length items have
// been taken. Each result item is a stream byte (kind 0), a checkpoint (kind 1, line and
// byte offset from the start of the header) or the end record (kind 2, total size), and
// last_of_run marks the final result of an input item. A front stage takes one line a
// cycle, encodes it and updates the bit packer; a two-entry job queue feeds a back stage
// that hands out one result a cycle while the receiver is ready, so a multi-result item
// holds the output side until all are taken while the front runs ahead until the queue
// fills. Lines that only add bits to the partial byte produce nothing and never reach the
// queue. After program_length is written, the first item of a nonzero-length program is
// held off while the header size is worked out with a registered reciprocal multiply; a
// write of program_length restarts that. Items past the end of the program are taken and
// dropped. program_length is written through cfg, which is always ready; the user must write
// it only while no result is outstanding, which the block does not enforce.
`default_nettype none

module line_delta_bitpack_encoder import ldbe_pkg::*; #(
  parameter int CHECKPOINT_SPACING = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ldbe_line_if.sink  lines,
  ldbe_cfg_if.sink   cfg,
  ldbe_rec_if.source records
);

  // front to queue
  logic q_ready;
  logic push;
  job_t push_job;

  // queue to back
  logic q_valid;
  logic pop;
  job_t q_head;

  // encoder, bit packer and header size
  ldbe_front #(
    .CHECKPOINT_SPACING(CHECKPOINT_SPACING)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .lines   (lines),
    .cfg     (cfg),
    .q_ready (q_ready),
    .push    (push),
    .job     (push_job)
  );

  // decouples encoding from result delivery
  ldbe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .ready    (q_ready),
    .pop      (pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // walks the result slots of one job, one result item a cycle while the receiver is ready
  ldbe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .records (records)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ldbe_hdr_div.sv =====
`default_nettype none

module ldbe_hdr_div import ldbe_pkg::*; #(
  parameter int CHECKPOINT_SPACING = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 abort,
  input  wire logic [LEN_W-1:0]     len,
  output logic                      busy,
  output logic                      done,
  output logic [LEN_W:0]            quotient
);

  localparam int NumW   = LEN_W + 1;
  localparam int RemW   = $clog2(CHECKPOINT_SPACING);
  localparam int Shift  = NumW + RemW;
  localparam int RecipW = NumW + 2;
  localparam int ProdW  = NumW + RecipW;
  // ceil(2^Shift / spacing), exact floor quotient for any numerator below 2^NumW
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << Shift) + 64'(CHECKPOINT_SPACING) - 64'd1) / 64'(CHECKPOINT_SPACING));

  logic [NumW-1:0]  num;
  logic [ProdW-1:0] prod;

  // reciprocal multiply, quotient registered in the cycle after the numerator
  always_comb begin
    prod = ProdW'(num) * ProdW'(Recip);
  end

  always_ff @(posedge clk) begin
    if (rst || abort) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // ceil(len / spacing) as floor((len + spacing - 1) / spacing)
      num <= NumW'(len) + NumW'(CHECKPOINT_SPACING - 1);
    end
    if (busy) begin
      quotient <= NumW'(prod >> Shift);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ldbe_front.sv =====
`default_nettype none
`include "assert_macros.svh"

module ldbe_front import ldbe_pkg::*; #(
  parameter int CHECKPOINT_SPACING = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  ldbe_line_if.sink lines,
  ldbe_cfg_if.sink  cfg,
  input  wire logic q_ready,
  output logic      push,
  output job_t      job
);

  localparam int PosW = $clog2(CHECKPOINT_SPACING);

  // architectural state
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  index;
  logic [PosW-1:0]   blk_pos;
  logic [LINE_W-1:0] prev;
  logic [PEND_W-1:0] pend;
  logic [PCNT_W-1:0] pc;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  header;
  logic              hdr_valid;

  logic              div_busy;
  logic              div_done;
  logic              div_start;
  logic [LEN_W:0]    div_q;

  logic              hdr_need;
  logic              accept;
  logic              ignore;
  logic              process;
  logic              first;
  logic              at_blk;
  logic              end_now;
  logic              pre;
  logic              ef;
  logic [LEN_W-1:0]  index_inc;

  logic signed [LINE_W:0] delta;
  logic [ACC_W-1:0]   code;
  logic [NBITS_W-1:0] nbits;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   aligned;
  logic [NBITS_W-1:0] cnt;
  logic [PCNT_W-1:0]  nb_eff;
  logic [PEND_W-1:0]  pend_new;
  logic [PEND_W-1:0]  pend_after;
  logic [PCNT_W-1:0]  pc_after;
  logic [PCNT_W-1:0]  incr;
  logic [POS_W-1:0]   pos_a;
  logic [POS_W-1:0]   pos_new;

  function automatic logic [BYTE_W-1:0] flush_byte(input logic [PEND_W-1:0] bits,
                                                    input logic [PCNT_W-1:0] n);
    logic [PEND_W+BYTE_W-1:0] t;
    t = {{BYTE_W{1'b0}}, bits} << (4'd8 - {1'b0, n});
    return t[BYTE_W-1:0];
  endfunction

  ldbe_hdr_div #(
    .CHECKPOINT_SPACING(CHECKPOINT_SPACING)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .abort    (cfg.valid),
    .len      (len),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cfg.ready   = 1'b1;
  assign hdr_need    = (index == '0) && (len != '0) && !hdr_valid;
  assign div_start   = hdr_need && !div_busy && !div_done;
  assign lines.ready = q_ready && !hdr_need;
  assign accept      = lines.valid && lines.ready;
  assign ignore      = index >= len;
  assign process     = accept && !ignore;
  assign push        = process && (|job.mask);

  always_comb begin
    first     = index == '0;
    at_blk    = blk_pos == '0;
    index_inc = index + 1'b1;
    end_now   = index_inc == len;

    // line delta and its prefix code
    delta = $signed({1'b0, lines.source_line}) - $signed({1'b0, prev});
    priority if (delta == '0) begin
      code  = '0;
      nbits = CODE_LEN_SAME;
    end else if (delta >= 1 && delta <= SHORT_MAX) begin
      code  = ACC_W'({PFX_SHORT, 2'(delta - 1)});
      nbits = CODE_LEN_SHORT;
    end else if (delta >= MID_MIN && delta <= MID_MAX) begin
      code  = ACC_W'({PFX_MID, 8'(delta + MID_BIAS)});
      nbits = CODE_LEN_MID;
    end else begin
      code  = ACC_W'({PFX_LONG, 1'b0, lines.source_line});
      nbits = CODE_LEN_LONG;
    end

    // append to the pending bits, left align for byte extraction
    acc      = ({{(ACC_W-PEND_W){1'b0}}, pend} << nbits) | code;
    cnt      = {{(NBITS_W-PCNT_W){1'b0}}, pc} + nbits;
    aligned  = acc << (NBITS_W'(ACC_W) - cnt);
    pend_new = acc[PEND_W-1:0] & ((PEND_W'(1) << cnt[2:0]) - PEND_W'(1));

    if (at_blk) begin
      pre        = !first && (pc != '0);
      nb_eff     = '0;
      pend_after = '0;
      pc_after   = '0;
    end else begin
      pre        = 1'b0;
      nb_eff     = cnt[5:3];
      pend_after = pend_new;
      pc_after   = cnt[2:0];
    end
    ef = end_now && (pc_after != '0);

    pos_a   = first ? header : pos;
    incr    = {2'b0, pre} + nb_eff + {2'b0, ef};
    pos_new = pos_a + POS_W'(incr);

    job.mask              = '0;
    job.bytes             = '0;
    job.mask[SLOT_PRE]    = pre;
    job.bytes[SLOT_PRE]   = flush_byte(pend, pc);
    job.mask[SLOT_CKPT]   = at_blk;
    for (int i = 0; i < MAX_STREAM_BYTES; i++) begin
      job.mask[SLOT_B0+i]  = PCNT_W'(i) < nb_eff;
      job.bytes[SLOT_B0+i] = aligned[ACC_W-1-BYTE_W*i -: BYTE_W];
    end
    job.mask[SLOT_EFLUSH]  = ef;
    job.bytes[SLOT_EFLUSH] = flush_byte(pend_after, pc_after);
    job.mask[SLOT_END]     = end_now;
    job.line               = lines.source_line;
    job.ckpt_off           = pos_a + POS_W'(pre);
    job.end_size           = pos_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      index     <= '0;
      blk_pos   <= '0;
      prev      <= '0;
      pend      <= '0;
      pc        <= '0;
      pos       <= '0;
      hdr_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        len       <= cfg.program_length;
        hdr_valid <= 1'b0;
      end else if (div_done) begin
        hdr_valid <= 1'b1;
      end
      if (process) begin
        index   <= index_inc;
        blk_pos <= (blk_pos == PosW'(CHECKPOINT_SPACING - 1)) ? '0 : blk_pos + 1'b1;
        prev    <= lines.source_line;
        pend    <= end_now ? '0 : pend_after;
        pc      <= end_now ? '0 : pc_after;
        pos     <= pos_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      header <= POS_W'(HEADER_BASE) + POS_W'(POS_W'(div_q) * CHECKPOINT_BYTES);
    end
  end

  `LDBE_ASSERT(a_hdr_ready, process && first |-> hdr_valid, "item 0 taken before header size")
  `LDBE_ASSERT(a_blk_align, index == '0 |-> blk_pos == '0, "block position out of step")
  `LDBE_ASSERT(a_div_hold, div_busy |-> !accept, "item taken while header divides")

endmodule

`default_nettype wire

// ===== hw/rtl/ldbe_queue.sv =====
`default_nettype none
`include "assert_macros.svh"

module ldbe_queue import ldbe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      ready,
  input  wire logic pop,
  output logic      valid,
  output job_t      head
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            full;

  assign full  = count == CntW'(QUEUE_DEPTH);
  assign ready = !full;
  assign valid = count != '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  `LDBE_ASSERT(a_no_overflow, push |-> !full, "job written into full queue")
  `LDBE_ASSERT(a_no_empty_job, push |-> push_job.mask != '0, "job without results queued")
  `LDBE_ASSERT(a_count_range, count <= CntW'(QUEUE_DEPTH), "queue count past depth")

endmodule

`default_nettype wire

// ===== hw/rtl/ldbe_back.sv =====
`default_nettype none
`include "assert_macros.svh"

module ldbe_back import ldbe_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_valid,
  input  job_t        q_head,
  output logic        pop,
  ldbe_rec_if.source  records
);

  job_t                 cur;
  logic [NUM_SLOTS-1:0] mask;
  logic [NUM_SLOTS-1:0] lowest;
  logic                 last;
  logic                 take;
  logic [BYTE_W-1:0]    byte_sel;

  assign lowest = mask & (~mask + 1'b1);
  assign last   = (mask & (mask - 1'b1)) == '0;
  assign take   = records.valid && records.ready;
  assign pop    = q_valid && ((mask == '0) || (take && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (pop) begin
      mask <= q_head.mask;
    end else if (take) begin
      mask <= mask & ~lowest;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

  always_comb begin
    byte_sel = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      byte_sel = byte_sel | (cur.bytes[i] & {BYTE_W{lowest[i]}});
    end
  end

  assign records.valid           = |mask;
  assign records.last_of_run     = last;
  assign records.data_byte       = byte_sel;
  assign records.kind            = lowest[SLOT_CKPT] ? KIND_CHECKPOINT :
                                   lowest[SLOT_END]  ? KIND_END : KIND_BYTE;
  assign records.checkpoint_line = lowest[SLOT_CKPT] ? cur.line : '0;
  assign records.byte_offset     = lowest[SLOT_CKPT] ? cur.ckpt_off :
                                   lowest[SLOT_END]  ? cur.end_size : '0;

  `LDBE_ASSERT(a_hold, records.valid && !records.ready |=> $stable(mask), "stalled job moved")
  `LDBE_ASSERT(a_run_cont, take && !last |=> records.valid, "job dropped before its last item")

endmodule

`default_nettype wire

// ===== tb/tb_line_delta_bitpack_encoder.sv =====
`timescale 1ns / 100ps

module tb_line_delta_bitpack_encoder;
  import ldbe_pkg::*;

  localparam int SPACING      = 64;
  // covers the pipe and the header size wait
  localparam int SETTLE       = 40;
  localparam int RANDOM_ITEMS = 288;
  localparam int SHOW_MAX     = 10;

  // one result item, field by field
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LINE_W-1:0] checkpoint_line;
    logic [POS_W-1:0]  byte_offset;
    logic              last_of_run;
  } record_t;

  // directed row: the line to send and, where obvious, the one record it gives
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic              typed;
    record_t           want;
  } dir_row_t;

  // first row opens the program: header = 4 + 8 * ceil(16777215 / 64) = 2097156
  localparam dir_row_t DIR_ROWS [22] = '{
    '{31'd1000, 1'b1, '{KIND_CHECKPOINT, 8'h00, 31'd1000, 32'd2097156, 1'b1}},
    '{31'd1000, 1'b0, '0},          // no change
    '{31'd1001, 1'b0, '0},          // +1
    '{31'd1005, 1'b0, '0},          // +4
    '{31'd1007, 1'b0, '0},          // +2
    '{31'd1010, 1'b0, '0},          // +3
    '{31'd882, 1'b0, '0},           // -128, low end of the mid code
    '{31'd1009, 1'b0, '0},          // +127, high end of the mid code
    '{31'd1137, 1'b0, '0},          // +128 falls to the absolute code
    '{31'd1008, 1'b0, '0},          // -129 falls to the absolute code
    '{31'd0, 1'b0, '0},             // line zero
    '{31'd0, 1'b0, '0},
    '{31'h7fffffff, 1'b0, '0},      // top line
    '{31'h7fffff7f, 1'b0, '0},
    '{31'h7ffffffe, 1'b0, '0},
    '{31'h7fffffff, 1'b0, '0},
    '{31'd0, 1'b0, '0},             // largest drop
    '{31'd5, 1'b0, '0},             // +5, just past the short code
    '{31'd1, 1'b0, '0},             // -4
    '{31'd0, 1'b0, '0},             // -1
    '{31'h2aaaaaaa, 1'b0, '0},
    '{31'h55555555, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  ldbe_line_if lines ();
  ldbe_cfg_if cfg ();
  ldbe_rec_if records ();

  line_delta_bitpack_encoder #(
    .CHECKPOINT_SPACING(SPACING)
  ) dut (
    .clk(clk),
    .rst(rst),
    .lines(lines),
    .cfg(cfg),
    .records(records)
  );

  always #10 clk = ~clk;

  // encoder state as the predictor sees it
  logic [LEN_W-1:0]  len_cfg    = '0;
  logic [LEN_W-1:0]  next_index = '0;
  logic [LINE_W-1:0] last_line  = '0;
  logic [PEND_W-1:0] spare_bits = '0;
  int                spare_cnt  = 0;
  logic [POS_W-1:0]  stream_pos = '0;

  record_t step_out[$];          // records of the item being predicted
  record_t expected_records[$];  // records still owed by the block
  int      faults = 0;
  bit      burst  = 1'b0;        // sender runs without gaps while set
  bit      steady = 1'b0;        // receiver starts no new stalls while set
  int      stall_left = 0;

  function automatic void add_record(kind_t k, logic [BYTE_W-1:0] b,
                                     logic [LINE_W-1:0] ln, logic [POS_W-1:0] off);
    record_t r;
    r.kind            = k;
    r.data_byte       = b;
    r.checkpoint_line = ln;
    r.byte_offset     = off;
    r.last_of_run     = 1'b0;
    step_out.push_back(r);
  endfunction

  // append a prefix code behind the spare bits, msb first, emitting whole bytes
  function automatic void pack_code(logic [34:0] code, int nbits);
    logic [47:0] acc;
    logic [47:0] sh;
    int cnt;
    acc = (48'(spare_bits) << nbits) | 48'(code);
    cnt = spare_cnt + nbits;
    while (cnt >= 8) begin
      cnt -= 8;
      sh = acc >> cnt;
      add_record(KIND_BYTE, sh[7:0], '0, '0);
      stream_pos++;
    end
    spare_bits = PEND_W'(acc & ((48'd1 << cnt) - 48'd1));
    spare_cnt  = cnt;
  endfunction

  // close the partial byte with zero padding
  function automatic void flush_spare();
    logic [7:0] b;
    if (spare_cnt > 0) begin
      b = {1'b0, spare_bits} << (8 - spare_cnt);
      add_record(KIND_BYTE, b, '0, '0);
      stream_pos++;
      spare_bits = '0;
      spare_cnt  = 0;
    end
  endfunction

  function automatic void predict_line(logic [LINE_W-1:0] ln);
    longint delta;
    logic [POS_W-1:0] blocks;
    step_out.delete();
    // past the end of the program: dropped
    if (next_index >= len_cfg) return;
    if (next_index % SPACING == 0) begin
      if (next_index == 0) begin
        // header size is fixed here, later length writes only move the end
        blocks     = (POS_W'(len_cfg) + SPACING - 1) / SPACING;
        stream_pos = HEADER_BASE + blocks * CHECKPOINT_BYTES;
        spare_bits = '0;
        spare_cnt  = 0;
      end else begin
        flush_spare();
      end
      add_record(KIND_CHECKPOINT, '0, ln, stream_pos);
    end else begin
      delta = longint'(ln) - longint'(last_line);
      if (delta == 0)
        pack_code('0, CODE_LEN_SAME);
      else if (delta >= 1 && delta <= SHORT_MAX)
        pack_code({PFX_SHORT, 2'(delta - 1)}, CODE_LEN_SHORT);
      else if (delta >= MID_MIN && delta <= MID_MAX)
        pack_code({PFX_MID, 8'(delta + MID_BIAS)}, CODE_LEN_MID);
      else
        pack_code({PFX_LONG, 1'b0, ln}, CODE_LEN_LONG);
    end
    last_line  = ln;
    next_index = next_index + 1'b1;
    if (next_index == len_cfg) begin
      flush_spare();
      add_record(KIND_END, '0, '0, stream_pos);
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int sender_gap();
    if (burst || $urandom_range(0, 99) < 50) return 0;
    return gap_len();
  endfunction

  // next line: mix of every code class, falling back to a random line at the edges
  function automatic logic [LINE_W-1:0] random_line();
    int sel;
    longint cand;
    sel = $urandom_range(0, 99);
    if (sel < 25)
      cand = last_line;
    else if (sel < 50)
      cand = longint'(last_line) + $urandom_range(1, 4);
    else if (sel < 75)
      cand = longint'(last_line) + longint'($urandom_range(0, 255)) - 128;
    else if (sel < 80)
      cand = longint'(last_line) + $urandom_range(128, 1000);
    else if (sel < 85)
      cand = longint'(last_line) - $urandom_range(129, 1000);
    else
      return LINE_W'($urandom());
    if (cand < 0 || cand > longint'(31'h7fffffff)) return LINE_W'($urandom());
    return LINE_W'(cand);
  endfunction

  // valid is left high on return so back-to-back items need no second assignment
  task automatic send_line(input logic [LINE_W-1:0] ln, input bit typed,
                           input record_t want);
    lines.valid       <= 1'b1;
    lines.source_line <= ln;
    @(posedge clk);
    while (!lines.ready) @(posedge clk);
    predict_line(ln);
    if (typed) begin
      step_out.delete();
      step_out.push_back(want);
    end
    foreach (step_out[i]) expected_records.push_back(step_out[i]);
  endtask

  task automatic idle_lines(input int n);
    if (n > 0) begin
      lines.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // sender holds off until every owed record is out
  task automatic wait_records_done();
    lines.valid <= 1'b0;
    @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
  endtask

  // idle point for a length write: items that only add bits may still be in flight
  task automatic drain();
    wait_records_done();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    cfg.valid          <= 1'b1;
    cfg.program_length <= len;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    len_cfg = len;
    cfg.valid <= 1'b0;
  endtask

  // receiver: random stalls, with stretches of none
  always @(posedge clk) begin
    if (rst) begin
      records.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) steady = !steady;
      if (stall_left > 0) begin
        records.ready <= 1'b0;
        stall_left--;
      end else begin
        records.ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 30) stall_left = gap_len();
      end
    end
  end

  // compare each accepted record with the oldest one owed
  always @(posedge clk) begin
    record_t got;
    record_t want;
    if (!rst && records.valid && records.ready) begin
      got.kind            = kind_t'(records.kind);
      got.data_byte       = records.data_byte;
      got.checkpoint_line = records.checkpoint_line;
      got.byte_offset     = records.byte_offset;
      got.last_of_run     = records.last_of_run;
      if (expected_records.size() == 0) begin
        faults++;
        if (faults <= SHOW_MAX)
          $display("unexpected record: kind %0d byte %h line %0d offset %0d last %0b",
                   got.kind, got.data_byte, got.checkpoint_line, got.byte_offset,
                   got.last_of_run);
      end else begin
        want = expected_records.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
            got.checkpoint_line !== want.checkpoint_line ||
            got.byte_offset !== want.byte_offset ||
            got.last_of_run !== want.last_of_run) begin
          faults++;
          if (faults <= SHOW_MAX)
            $display("record mismatch: want kind %0d byte %h line %0d offset %0d last %0b",
                     want.kind, want.data_byte, want.checkpoint_line, want.byte_offset,
                     want.last_of_run, "; got kind %0d byte %h line %0d offset %0d last %0b",
                     got.kind, got.data_byte, got.checkpoint_line, got.byte_offset,
                     got.last_of_run);
        end
      end
    end
  end

  initial begin
    int      sent;
    int      n;
    int      sel;
    record_t none;
    none = '0;
    sent = 0;
    rst                <= 1'b1;
    lines.valid        <= 1'b0;
    lines.source_line  <= '0;
    cfg.valid          <= 1'b0;
    cfg.program_length <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE) @(posedge clk);

    // length still zero from reset: both items are dropped
    send_line(31'h7fffffff, 1'b0, none);
    send_line(LINE_W'($urandom()), 1'b0, none);
    drain();

    // longest program, so the header offset is at its largest
    write_length(24'hffffff);
    foreach (DIR_ROWS[i]) begin
      send_line(DIR_ROWS[i].line, DIR_ROWS[i].typed, DIR_ROWS[i].want);
      idle_lines(sender_gap());
    end
    drain();

    // cut the program short: block is finished without an end record
    write_length('0);
    send_line(LINE_W'($urandom()), 1'b0, none);
    drain();

    // each phase extends the program and runs it to its end record
    while (sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: begin
          n = 1;
        end
        1: begin
          // checkpoint item is also the last one
          n = SPACING - next_index % SPACING + 1;
        end
        2: begin
          // end lands just before a block boundary
          n = SPACING - next_index % SPACING;
        end
        default: begin
          n = $urandom_range(2, 70);
        end
      endcase
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      write_length(LEN_W'(next_index + n));
      repeat (n) begin
        send_line(random_line(), 1'b0, none);
        sent++;
        if ($urandom_range(0, 29) == 0) burst = !burst;
        if ($urandom_range(0, 99) < 3)
          wait_records_done();
        else
          idle_lines(sender_gap());
      end
      // a few items past the end, which the block drops
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) send_line(random_line(), 1'b0, none);
      drain();
    end

    if (faults == 0 && expected_records.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
